/* design/rbes_pkg.sv */
// Package: request/response types, operation codes and register indexes.
`timescale 1ns / 1ps
`default_nettype none
package rbes_pkg;

   localparam int unsigned VAL_W  = 32;
   localparam int unsigned CAP_W  = 31;
   localparam int unsigned DT_W   = 17;
   localparam int unsigned OP_W   = 3;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned SUM_W  = 64;
   localparam int unsigned ROOT_W = 32;

   localparam logic [VAL_W-1:0] GRAVITY_RESET = 32'hFF9E_0000;
   localparam logic [CAP_W-1:0] CAP_RESET     = 31'h7FFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_STEP    = 3'd0,
      OP_SET_VEL = 3'd1,
      OP_SET_ACC = 3'd2,
      OP_ADD_ACC = 3'd3,
      OP_ADD_VEL = 3'd4,
      OP_ADD_POS = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY_ACCEL  = 3'd0,
      CSR_GRAVITY_ENABLE = 3'd1,
      CSR_VEL_CAP_X      = 3'd2,
      CSR_VEL_CAP_Y      = 3'd3,
      CSR_VEL_CAP_Z      = 3'd4,
      CSR_ACCEL_CAP      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [DT_W-1:0]         time_step;
      logic signed [VAL_W-1:0] vec_x;
      logic signed [VAL_W-1:0] vec_y;
      logic signed [VAL_W-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] pos_x;
      logic signed [VAL_W-1:0] pos_y;
      logic signed [VAL_W-1:0] pos_z;
      logic signed [VAL_W-1:0] vel_x;
      logic signed [VAL_W-1:0] vel_y;
      logic signed [VAL_W-1:0] vel_z;
      logic signed [VAL_W-1:0] acc_x;
      logic signed [VAL_W-1:0] acc_y;
      logic signed [VAL_W-1:0] acc_z;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] gravity_accel;
      logic                    gravity_enable;
      logic [CAP_W-1:0]        vel_cap_x;
      logic [CAP_W-1:0]        vel_cap_y;
      logic [CAP_W-1:0]        vel_cap_z;
      logic [CAP_W-1:0]        accel_cap;
   } csr_type;

   // Datapath commands from the controller.
   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,      // snapshot velocity, clear a^2 sum
      CMD_SIMPLE,    // non-step operation
      CMD_POS,       // position += v*dt, one axis per cycle
      CMD_VEL,       // velocity += a*dt
      CMD_GRAV,      // gravity into acc y, velocity clamps
      CMD_SQ,        // accumulate a^2, one axis per cycle
      CMD_CHECK,     // compare against cap^2
      CMD_SQRT,      // one root step
      CMD_MUL,       // |a|*cap, one axis
      CMD_DIV,       // one quotient bit
      CMD_WB         // write scaled axis
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [1:0]  axis;
   } ctl_type;

   typedef struct packed {
      logic over_cap;
      logic sqrt_done;
      logic div_done;
   } sts_type;

   function automatic logic signed [VAL_W-1:0] sat_add(
      input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
      logic signed [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1])
         return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      return s[VAL_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* design/rigid_body_euler_step.sv */
// Top level: 3-D explicit Euler integrator with velocity and acceleration caps.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_ready | rbes_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_ready | rbes_pkg::rsp_type
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One request at a time. Step requests add a scaling pass when the
// acceleration exceeds its cap, using the bit-serial root and divide
// units. Synchronous reset clears state and restores register defaults.
// The response holds until rsp_ready; req_ready and csr_ready are low
// meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_euler_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rbes_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rbes_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [rbes_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rbes_pkg::VAL_W-1:0]     csr_data
);
   rbes_pkg::csr_type csr_ff;
   rbes_pkg::ctl_type ctl;
   rbes_pkg::sts_type sts;
   logic busy, is_step, req_fire;

   assign req_ready = !busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gravity_accel  <= rbes_pkg::GRAVITY_RESET;
         csr_ff.gravity_enable <= 1'b1;
         csr_ff.vel_cap_x      <= rbes_pkg::CAP_RESET;
         csr_ff.vel_cap_y      <= rbes_pkg::CAP_RESET;
         csr_ff.vel_cap_z      <= rbes_pkg::CAP_RESET;
         csr_ff.accel_cap      <= rbes_pkg::CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rbes_pkg::CSR_GRAVITY_ACCEL:  csr_ff.gravity_accel  <= csr_data;
            rbes_pkg::CSR_GRAVITY_ENABLE: csr_ff.gravity_enable <= csr_data[0];
            rbes_pkg::CSR_VEL_CAP_X: csr_ff.vel_cap_x <= csr_data[rbes_pkg::CAP_W-1:0];
            rbes_pkg::CSR_VEL_CAP_Y: csr_ff.vel_cap_y <= csr_data[rbes_pkg::CAP_W-1:0];
            rbes_pkg::CSR_VEL_CAP_Z: csr_ff.vel_cap_z <= csr_data[rbes_pkg::CAP_W-1:0];
            rbes_pkg::CSR_ACCEL_CAP: csr_ff.accel_cap <= csr_data[rbes_pkg::CAP_W-1:0];
            default: ;
         endcase
      end
   end

   rbes_ctrl u_ctrl (
      .clock, .reset, .req_fire, .is_step,
      .rsp_fire(rsp_valid && rsp_ready), .sts, .ctl, .busy, .rsp_valid
   );

   rbes_dpath u_dpath (
      .clock, .reset, .req_fire, .req_data, .csr(csr_ff), .ctl, .sts,
      .is_step, .rsp_data
   );
endmodule
`default_nettype wire

/* design/rbes_ctrl.sv */
// Controller: sequences one request through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module rbes_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire logic             is_step,
   input  wire logic             rsp_fire,
   input  wire rbes_pkg::sts_type sts,
   output rbes_pkg::ctl_type     ctl,
   output logic                  busy,
   output logic                  rsp_valid
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_SIMPLE, S_POS, S_VEL, S_GRAV, S_SQ, S_CHECK,
      S_SQRT, S_MUL, S_DIV, S_WB, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 2'd0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_fire) state_ff <= S_LOAD;
            S_LOAD: begin
               axis_ff  <= 2'd0;
               state_ff <= is_step ? S_POS : S_SIMPLE;
            end
            S_SIMPLE: state_ff <= S_OUT;
            S_POS: begin
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
               if (axis_ff == 2'd2) state_ff <= S_VEL;
            end
            S_VEL: begin
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
               if (axis_ff == 2'd2) state_ff <= S_GRAV;
            end
            S_GRAV: state_ff <= S_SQ;
            S_SQ: begin
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
               if (axis_ff == 2'd2) state_ff <= S_CHECK;
            end
            S_CHECK: state_ff <= sts.over_cap ? S_SQRT : S_OUT;
            S_SQRT: if (sts.sqrt_done) state_ff <= S_MUL;
            S_MUL: state_ff <= S_DIV;
            S_DIV: if (sts.div_done) state_ff <= S_WB;
            S_WB: begin
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
               state_ff <= (axis_ff == 2'd2) ? S_OUT : S_MUL;
            end
            S_OUT: if (rsp_fire) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      ctl.axis = axis_ff;
      case (state_ff)
         S_LOAD:   ctl.cmd = rbes_pkg::CMD_LOAD;
         S_SIMPLE: ctl.cmd = rbes_pkg::CMD_SIMPLE;
         S_POS:    ctl.cmd = rbes_pkg::CMD_POS;
         S_VEL:    ctl.cmd = rbes_pkg::CMD_VEL;
         S_GRAV:   ctl.cmd = rbes_pkg::CMD_GRAV;
         S_SQ:     ctl.cmd = rbes_pkg::CMD_SQ;
         S_CHECK:  ctl.cmd = rbes_pkg::CMD_CHECK;
         S_SQRT:   ctl.cmd = rbes_pkg::CMD_SQRT;
         S_MUL:    ctl.cmd = rbes_pkg::CMD_MUL;
         S_DIV:    ctl.cmd = rbes_pkg::CMD_DIV;
         S_WB:     ctl.cmd = rbes_pkg::CMD_WB;
         default:  ctl.cmd = rbes_pkg::CMD_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule
`default_nettype wire

/* design/rbes_dpath.sv */
// Datapath: state vectors, dt multiplier, root and divide units.
`timescale 1ns / 1ps
`default_nettype none
module rbes_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire rbes_pkg::req_type req_data,
   input  wire rbes_pkg::csr_type csr,
   input  wire rbes_pkg::ctl_type ctl,
   output rbes_pkg::sts_type      sts,
   output logic                   is_step,
   output rbes_pkg::rsp_type      rsp_data
);
   localparam int unsigned W  = rbes_pkg::VAL_W;
   localparam int unsigned SW = rbes_pkg::SUM_W;
   localparam int unsigned RW = rbes_pkg::ROOT_W;
   localparam int unsigned PW = W + rbes_pkg::CAP_W; // |a|*cap width
   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0] pos_ff [3];
   logic signed [W-1:0] vel_ff [3];
   logic signed [W-1:0] acc_ff [3];
   logic signed [W-1:0] vold_ff [3];
   rbes_pkg::req_type   req_ff;

   logic [SW-1:0]  sum_ff;
   logic [SW-1:0]  rem_ff;
   logic [RW-1:0]  root_ff;
   logic [4:0]     sq_cnt_ff;
   logic           sq_done_ff;
   logic [PW-1:0]  dividend_ff;
   logic [RW:0]    drem_ff;
   logic [PW-1:0]  quot_ff;
   logic [5:0]     dcnt_ff;
   logic           ddone_ff;

   // v*dt with floor shift and saturation
   function automatic logic signed [W-1:0] mul_dt(
      input logic signed [W-1:0] v, input logic [rbes_pkg::DT_W-1:0] dt);
      logic signed [W+rbes_pkg::DT_W:0] p;
      logic signed [W+rbes_pkg::DT_W-16:0] q;
      p = v * $signed({1'b0, dt});
      q = p[W+rbes_pkg::DT_W:16];
      if (q > $signed({{(rbes_pkg::DT_W-15){1'b0}}, SMAX})) return SMAX;
      if (q < $signed({{(rbes_pkg::DT_W-15){1'b1}}, SMIN})) return SMIN;
      return q[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] clamp(
      input logic signed [W-1:0] v, input logic [rbes_pkg::CAP_W-1:0] cap);
      logic signed [W-1:0] c;
      c = $signed({1'b0, cap});
      if (!v[W-1]) return (v > c) ? c : v;
      return (v < -c) ? -c : v;
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
      return a[W-1] ? W'(-a) : a;
   endfunction

   logic signed [W-1:0] pick_acc;
   logic [W-1:0]        amag;
   logic [SW-1:0]       sq_bit;
   logic [RW:0]         dshift;
   logic [SW-1:0]       cap_sq;

   assign pick_acc = acc_ff[ctl.axis];
   assign amag     = mag(pick_acc);
   assign sq_bit   = SW'(1) << {sq_cnt_ff, 1'b0};
   assign cap_sq   = SW'(csr.accel_cap) * SW'(csr.accel_cap);
   assign dshift   = {drem_ff[RW-1:0], dividend_ff[PW-1]};

   logic [SW-1:0] rtrial;
   assign rtrial = (SW'(root_ff) << (sq_cnt_ff + 5'd1)) + sq_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
         sq_done_ff <= 1'b0;
         ddone_ff   <= 1'b0;
      end else begin
         if (req_fire) req_ff <= req_data;
         case (ctl.cmd)
            rbes_pkg::CMD_LOAD: begin
               for (int i = 0; i < 3; i++) vold_ff[i] <= vel_ff[i];
               sum_ff <= '0;
            end
            rbes_pkg::CMD_SIMPLE: begin
               case (req_ff.operation)
                  rbes_pkg::OP_SET_VEL: begin
                     vel_ff[0] <= req_ff.vec_x; vel_ff[1] <= req_ff.vec_y;
                     vel_ff[2] <= req_ff.vec_z;
                  end
                  rbes_pkg::OP_SET_ACC: begin
                     acc_ff[0] <= req_ff.vec_x; acc_ff[1] <= req_ff.vec_y;
                     acc_ff[2] <= req_ff.vec_z;
                  end
                  rbes_pkg::OP_ADD_ACC: begin
                     acc_ff[0] <= rbes_pkg::sat_add(acc_ff[0], req_ff.vec_x);
                     acc_ff[1] <= rbes_pkg::sat_add(acc_ff[1], req_ff.vec_y);
                     acc_ff[2] <= rbes_pkg::sat_add(acc_ff[2], req_ff.vec_z);
                  end
                  rbes_pkg::OP_ADD_VEL: begin
                     vel_ff[0] <= rbes_pkg::sat_add(vel_ff[0], req_ff.vec_x);
                     vel_ff[1] <= rbes_pkg::sat_add(vel_ff[1], req_ff.vec_y);
                     vel_ff[2] <= rbes_pkg::sat_add(vel_ff[2], req_ff.vec_z);
                  end
                  rbes_pkg::OP_ADD_POS: begin
                     pos_ff[0] <= rbes_pkg::sat_add(pos_ff[0], req_ff.vec_x);
                     pos_ff[1] <= rbes_pkg::sat_add(pos_ff[1], req_ff.vec_y);
                     pos_ff[2] <= rbes_pkg::sat_add(pos_ff[2], req_ff.vec_z);
                  end
                  default: ;
               endcase
            end
            rbes_pkg::CMD_POS:
               pos_ff[ctl.axis] <= rbes_pkg::sat_add(pos_ff[ctl.axis],
                                      mul_dt(vold_ff[ctl.axis], req_ff.time_step));
            rbes_pkg::CMD_VEL:
               vel_ff[ctl.axis] <= rbes_pkg::sat_add(vel_ff[ctl.axis],
                                      mul_dt(pick_acc, req_ff.time_step));
            rbes_pkg::CMD_GRAV: begin
               if (csr.gravity_enable)
                  acc_ff[1] <= rbes_pkg::sat_add(acc_ff[1],
                                  mul_dt(csr.gravity_accel, req_ff.time_step));
               vel_ff[0] <= clamp(vel_ff[0], csr.vel_cap_x);
               vel_ff[1] <= clamp(vel_ff[1], csr.vel_cap_y);
               vel_ff[2] <= clamp(vel_ff[2], csr.vel_cap_z);
            end
            rbes_pkg::CMD_SQ: sum_ff <= sum_ff + SW'(amag) * SW'(amag);
            rbes_pkg::CMD_CHECK: begin
               rem_ff     <= sum_ff;
               root_ff    <= '0;
               sq_cnt_ff  <= 5'd31;
               sq_done_ff <= 1'b0;
            end
            rbes_pkg::CMD_SQRT: begin
               // one result bit per cycle, restoring method
               if (!sq_done_ff) begin
                  if (rem_ff >= rtrial) begin
                     rem_ff  <= rem_ff - rtrial;
                     root_ff <= root_ff | (RW'(1) << sq_cnt_ff);
                  end
                  if (sq_cnt_ff == 5'd0) sq_done_ff <= 1'b1;
                  else sq_cnt_ff <= sq_cnt_ff - 5'd1;
               end
            end
            rbes_pkg::CMD_MUL: begin
               dividend_ff <= PW'(amag) * PW'(csr.accel_cap);
               drem_ff     <= '0;
               quot_ff     <= '0;
               dcnt_ff     <= 6'(PW - 1);
               ddone_ff    <= 1'b0;
            end
            rbes_pkg::CMD_DIV: begin
               if (!ddone_ff) begin
                  if (dshift >= {1'b0, root_ff}) begin
                     drem_ff <= dshift - {1'b0, root_ff};
                     quot_ff <= {quot_ff[PW-2:0], 1'b1};
                  end else begin
                     drem_ff <= dshift;
                     quot_ff <= {quot_ff[PW-2:0], 1'b0};
                  end
                  dividend_ff <= {dividend_ff[PW-2:0], 1'b0};
                  if (dcnt_ff == 6'd0) ddone_ff <= 1'b1;
                  else dcnt_ff <= dcnt_ff - 6'd1;
               end
            end
            rbes_pkg::CMD_WB:
               acc_ff[ctl.axis] <= pick_acc[W-1] ? W'(-quot_ff[W-1:0]) : quot_ff[W-1:0];
            default: ;
         endcase
      end
   end

   assign sts.over_cap  = (cap_sq < sum_ff) && (sum_ff != '0);
   assign sts.sqrt_done = sq_done_ff;
   assign sts.div_done  = ddone_ff;
   assign is_step       = (req_ff.operation == rbes_pkg::OP_STEP);

   assign rsp_data.pos_x = pos_ff[0];
   assign rsp_data.pos_y = pos_ff[1];
   assign rsp_data.pos_z = pos_ff[2];
   assign rsp_data.vel_x = vel_ff[0];
   assign rsp_data.vel_y = vel_ff[1];
   assign rsp_data.vel_z = vel_ff[2];
   assign rsp_data.acc_x = acc_ff[0];
   assign rsp_data.acc_y = acc_ff[1];
   assign rsp_data.acc_z = acc_ff[2];
endmodule
`default_nettype wire
